@@ design/trb_pkg.sv @@
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, register codes and window compare helpers for the reorder
// buffer.
// ----------------------------------------------------------------------------
package trb_pkg;

	typedef enum logic [1:0] {
		REG_DELAY = 2'd0,
		REG_AHEAD = 2'd1,
		REG_LIMIT = 2'd2
	} reg_idx_t;

	localparam logic OP_ROW = 1'b0;
	localparam logic OP_EOS = 1'b1;

	localparam logic signed [63:0] DELAY_RESET = -64'sd1000000;
	localparam logic signed [63:0] AHEAD_RESET = 64'sd1000000;
	localparam logic [4:0]         LIMIT_RESET = 5'd31;

	typedef struct packed {
		logic signed [63:0] delay_offset;
		logic signed [63:0] ahead_offset;
		logic [4:0]         row_limit;
	} cfg_t;

	// a + b < c, sum formed at 65 bits
	function automatic logic sum_lt(input logic signed [63:0] a,
		input logic signed [63:0] b, input logic signed [63:0] c);
		logic signed [64:0] s;
		logic signed [64:0] r;
		s = $signed({a[63], a}) + $signed({b[63], b});
		r = $signed({c[63], c});
		return s < r;
	endfunction

	// a + b > c, sum formed at 65 bits
	function automatic logic sum_gt(input logic signed [63:0] a,
		input logic signed [63:0] b, input logic signed [63:0] c);
		logic signed [64:0] s;
		logic signed [64:0] r;
		s = $signed({a[63], a}) + $signed({b[63], b});
		r = $signed({c[63], c});
		return s > r;
	endfunction

endpackage

@@ design/trb_ram.sv @@
// ----------------------------------------------------------------------------
// trb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module trb_ram #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/trb_front.sv @@
// ----------------------------------------------------------------------------
// trb_front
// Input side: accepts transactions, decodes the opcode and queues them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module trb_front #(
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic signed [63:0]       timestamp,
	input  logic [PAYLOAD_WIDTH-1:0] payload,
	output logic                     q_valid,
	input  logic                     q_pop,
	output logic                     q_eos,
	output logic signed [63:0]       q_time,
	output logic [PAYLOAD_WIDTH-1:0] q_data
);

	logic                     eos_q  [2];
	logic signed [63:0]       time_q [2];
	logic [PAYLOAD_WIDTH-1:0] data_q [2];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               cnt_q;
	logic                     push;
	logic                     pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_eos    = eos_q[rd_ptr_q];
	assign q_time   = time_q[rd_ptr_q];
	assign q_data   = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			eos_q[wr_ptr_q]  <= (opcode == trb_pkg::OP_EOS);
			time_q[wr_ptr_q] <= timestamp;
			data_q[wr_ptr_q] <= payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ design/trb_back.sv @@
// ----------------------------------------------------------------------------
// trb_back
// Back end: keeps the store in RAM, finds the oldest entry by a scan, applies
// the window and release rules and drives the output register.
// ----------------------------------------------------------------------------
module trb_back #(
	parameter int MAX_ENTRIES   = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  trb_pkg::cfg_t            cfg,
	input  logic                     q_valid,
	output logic                     q_pop,
	input  logic                     q_eos,
	input  logic signed [63:0]       q_time,
	input  logic [PAYLOAD_WIDTH-1:0] q_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [63:0]       out_time,
	output logic [PAYLOAD_WIDTH-1:0] out_payload,
	output logic                     out_of_order,
	output logic                     end_of_stream,
	output logic                     last
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int RW = 128 + PAYLOAD_WIDTH;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_DRAIN   = 7'b0000010,
		S_SCAN    = 7'b0000100,
		S_DECIDE  = 7'b0001000,
		S_MOVE    = 7'b0010000,
		S_RESOLVE = 7'b0100000,
		S_FINISH  = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic signed [63:0]       latest_q;
	logic                     term_q;
	logic [63:0]              arrival_q;
	logic                     cur_eos_q;
	logic                     post_q;
	logic signed [63:0]       cur_time_q;
	logic [PAYLOAD_WIDTH-1:0] cur_data_q;
	logic [CW-1:0]            scan_idx_q;
	logic                     rd_vld_q;
	logic [AW-1:0]            rd_idx_q;
	logic                     best_vld_q;
	logic [AW-1:0]            best_idx_q;
	logic signed [63:0]       best_time_q;
	logic [63:0]              best_seq_q;
	logic [PAYLOAD_WIDTH-1:0] best_data_q;
	logic                     held_vld_q;
	logic signed [63:0]       held_time_q;
	logic [PAYLOAD_WIDTH-1:0] held_data_q;
	logic                     held_ooo_q;
	logic                     held_eos_q;
	logic                     out_vld_q;
	logic signed [63:0]       out_time_q;
	logic [PAYLOAD_WIDTH-1:0] out_data_q;
	logic                     out_ooo_q;
	logic                     out_eos_q;
	logic                     out_last_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [RW-1:0]            ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic [RW-1:0]            ram_rdata;
	logic signed [63:0]       rd_time;
	logic [63:0]              rd_seq;
	logic [PAYLOAD_WIDTH-1:0] rd_data;

	logic                     slot_free;
	logic                     emit_ok;
	logic                     emit_req;
	logic signed [63:0]       emit_time;
	logic [PAYLOAD_WIDTH-1:0] emit_data;
	logic                     emit_ooo;
	logic                     emit_eos;
	logic                     push;
	logic                     rd_issue;
	logic                     older;
	logic                     full;
	logic                     release_now;
	logic signed [63:0]       latest_eff;
	logic                     win_ok;
	logic [CW-1:0]            last_idx;

	assign rd_time = ram_rdata[RW-1 -: 64];
	assign rd_seq  = ram_rdata[RW-65 -: 64];
	assign rd_data = ram_rdata[PAYLOAD_WIDTH-1:0];

	always_comb begin
		slot_free   = !out_vld_q || !out_stall;
		emit_ok     = !held_vld_q || slot_free;
		last_idx    = count_q - CW'(1);
		rd_issue    = (state_q == S_SCAN) && (scan_idx_q < count_q);
		older       = !best_vld_q || (rd_time < best_time_q) ||
			((rd_time == best_time_q) && (rd_seq < best_seq_q));
		// store is full at the smaller of row_limit+1 and capacity
		full        = (7'(count_q) >= (7'(cfg.row_limit) + 7'd1)) ||
			(count_q >= MAX_CNT);
		release_now = trb_pkg::sum_gt(latest_q, cfg.delay_offset, best_time_q) ||
			full || term_q;
		latest_eff  = (count_q == '0) ? cur_time_q : latest_q;
		win_ok      = trb_pkg::sum_lt(latest_eff, cfg.delay_offset, cur_time_q) &&
			trb_pkg::sum_gt(latest_eff, cfg.ahead_offset, cur_time_q) &&
			(count_q < MAX_CNT);

		emit_req  = 1'b0;
		emit_time = best_time_q;
		emit_data = best_data_q;
		emit_ooo  = 1'b0;
		emit_eos  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid && term_q) begin
					emit_req  = 1'b1;
					emit_time = '0;
					emit_data = '0;
					emit_eos  = 1'b1;
				end
			end
			S_DECIDE: begin
				emit_req = release_now;
			end
			S_RESOLVE: begin
				if (cur_eos_q) begin
					emit_req  = 1'b1;
					emit_time = '0;
					emit_data = '0;
					emit_eos  = 1'b1;
				end else if (!post_q && !win_ok) begin
					emit_req  = 1'b1;
					emit_time = cur_time_q;
					emit_data = cur_data_q;
					emit_ooo  = 1'b1;
				end
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase

		push = emit_ok && held_vld_q && (emit_req || (state_q == S_FINISH));
		q_pop = (state_q == S_IDLE);

		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = (state_q == S_DECIDE) ? last_idx[AW-1:0] : scan_idx_q[AW-1:0];
		if (state_q == S_MOVE) begin
			ram_we = 1'b1;
		end else if ((state_q == S_RESOLVE) && !cur_eos_q && !post_q && win_ok) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = {cur_time_q, arrival_q + 64'd1, cur_data_q};
		end
	end

	trb_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			cur_time_q <= q_time;
			cur_data_q <= q_data;
		end
		rd_idx_q <= scan_idx_q[AW-1:0];
		if (rd_vld_q && older) begin
			best_idx_q  <= rd_idx_q;
			best_time_q <= rd_time;
			best_seq_q  <= rd_seq;
			best_data_q <= rd_data;
		end
		if (emit_req && emit_ok) begin
			held_time_q <= emit_time;
			held_data_q <= emit_data;
			held_ooo_q  <= emit_ooo;
			held_eos_q  <= emit_eos;
		end
		if (push) begin
			out_time_q <= held_time_q;
			out_data_q <= held_data_q;
			out_ooo_q  <= held_ooo_q;
			out_eos_q  <= held_eos_q;
			out_last_q <= (state_q == S_FINISH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			latest_q   <= '0;
			term_q     <= 1'b0;
			arrival_q  <= '0;
			cur_eos_q  <= 1'b0;
			post_q     <= 1'b0;
			scan_idx_q <= '0;
			rd_vld_q   <= 1'b0;
			best_vld_q <= 1'b0;
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= rd_issue;
			if (rd_vld_q) begin
				best_vld_q <= 1'b1;
			end
			if (emit_req && emit_ok) begin
				held_vld_q <= 1'b1;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_eos_q <= q_eos;
						post_q    <= 1'b0;
						if (term_q) begin
							state_q <= S_FINISH;
						end else begin
							if (q_eos) begin
								term_q <= 1'b1;
							end
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					scan_idx_q <= '0;
					best_vld_q <= 1'b0;
					state_q    <= (count_q == '0) ? S_RESOLVE : S_SCAN;
				end
				S_SCAN: begin
					if (rd_issue) begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end else if (!rd_vld_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!release_now) begin
						state_q <= S_RESOLVE;
					end else if (emit_ok) begin
						if (best_idx_q == last_idx[AW-1:0]) begin
							count_q <= last_idx;
							state_q <= S_DRAIN;
						end else begin
							state_q <= S_MOVE;
						end
					end
				end
				S_MOVE: begin
					// last entry fills the hole left by the released one
					count_q <= last_idx;
					state_q <= S_DRAIN;
				end
				S_RESOLVE: begin
					if (cur_eos_q) begin
						if (emit_ok) begin
							state_q <= S_FINISH;
						end
					end else if (post_q) begin
						state_q <= S_FINISH;
					end else if (win_ok) begin
						arrival_q <= arrival_q + 64'd1;
						count_q   <= count_q + CW'(1);
						latest_q  <= (cur_time_q > latest_eff) ? cur_time_q : latest_eff;
						post_q    <= 1'b1;
						state_q   <= S_DRAIN;
					end else if (emit_ok) begin
						latest_q <= latest_eff;
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (emit_ok) begin
						held_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_vld_q;
	assign out_time      = out_time_q;
	assign out_payload   = out_data_q;
	assign out_of_order  = out_ooo_q;
	assign end_of_stream = out_eos_q;
	assign last          = out_last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("store count above capacity");

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !held_vld_q)
		else $error("result left behind between transactions");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (state_q == S_SCAN))
		else $error("scan read returned outside scan");

	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("move did not shrink store");
`endif

endmodule

@@ design/timestamp_reorder_buffer.sv @@
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer
// Restores time order of a stream of timestamped rows using a release window.
// ----------------------------------------------------------------------------
// Each transaction is queued (two deep) and then handled by a sequencer that
// keeps the rows in one RAM. Finding the oldest row is a scan of the store, one
// RAM read per cycle, and a released row leaves a slot into which the last entry
// is moved. A row that only enters the store takes two passes. A row whose time
// is outside the window is sent out at once with out_of_order set; end of stream
// empties the store in order and then sends an end marker, and an input after
// end of stream sends another end marker. Results leave through a registered
// output with last on the final result of each input. Configuration is to be
// written only while the block is idle; the block itself does not enforce this.
module timestamp_reorder_buffer #(
	parameter int MAX_ENTRIES   = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [63:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic signed [63:0]       timestamp,
	input  logic [PAYLOAD_WIDTH-1:0] payload,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [63:0]       out_time,
	output logic [PAYLOAD_WIDTH-1:0] out_payload,
	output logic                     out_of_order,
	output logic                     end_of_stream,
	output logic                     last
);

	trb_pkg::cfg_t            cfg_q;
	logic                     q_valid;
	logic                     q_pop;
	logic                     q_eos;
	logic signed [63:0]       q_time;
	logic [PAYLOAD_WIDTH-1:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_offset <= trb_pkg::DELAY_RESET;
			cfg_q.ahead_offset <= trb_pkg::AHEAD_RESET;
			cfg_q.row_limit    <= trb_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				trb_pkg::REG_DELAY: cfg_q.delay_offset <= cfg_data;
				trb_pkg::REG_AHEAD: cfg_q.ahead_offset <= cfg_data;
				trb_pkg::REG_LIMIT: cfg_q.row_limit    <= cfg_data[4:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	trb_front #(
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.timestamp(timestamp),
		.payload  (payload),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_eos    (q_eos),
		.q_time   (q_time),
		.q_data   (q_data)
	);

	trb_back #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_eos        (q_eos),
		.q_time       (q_time),
		.q_data       (q_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_time     (out_time),
		.out_payload  (out_payload),
		.out_of_order (out_of_order),
		.end_of_stream(end_of_stream),
		.last         (last)
	);

endmodule
